FILE: rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types and constants for the run-length tag stream decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

   // tag split: below is a literal run, at or above is a repeat
   localparam logic [7:0] TAG_SPLIT = 8'h80;

   // depth of the command queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CORRUPT = 2'd1,
      STATUS_LIMIT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_LITERAL,
      CMD_REPEAT,
      CMD_STATUS
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_data_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [7:0]  out_count;
      logic        out_final;
      logic [1:0]  out_status;
      logic [15:0] out_total;
   } rsp_data_type;

   // command from the front to the back
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [7:0]   count;
      logic         final_flag;
      status_type   status;
      logic [15:0]  total;
   } cmd_type;

endpackage

FILE: rtl/rtd_front.sv
// ----------------------------------------------------------------------------
// rtd_front
// Takes compressed bytes, tracks the stream state and issues commands.
// ----------------------------------------------------------------------------
module rtd_front #(
   parameter int LEN_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   input  logic                  req_valid,
   input  rtd_pkg::req_data_type req_data,
   input  logic                  queue_full,
   output logic                  req_ready,
   output logic                  cmd_push,
   output rtd_pkg::cmd_type      cmd
);

   localparam int CMP_W = ((LEN_WIDTH > 16) ? LEN_WIDTH : 16) + 1;

   logic                   in_literal_ff, in_literal_in;
   logic [7:0]             literal_left_ff, literal_left_in;
   logic [LEN_WIDTH-1:0]   produced_ff, produced_in;
   rtd_pkg::status_type    failed_ff, failed_in;
   logic                   limit_reached_ff, limit_reached_in;
   logic [15:0]            limit_ff;

   logic                   accept;
   logic [CMP_W-1:0]       produced_wide;
   logic [CMP_W-1:0]       limit_wide;
   logic [CMP_W-1:0]       run_len;
   logic [CMP_W-1:0]       run_sum;
   logic [LEN_WIDTH-1:0]   run_next;
   logic [LEN_WIDTH-1:0]   lit_next;
   logic                   run_over;
   logic                   at_limit;
   logic [15:0]            produced_total;
   rtd_pkg::status_type    fail_code;
   logic                   clear;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // run length, the adds and the compares against the limit
   assign produced_wide  = CMP_W'(produced_ff);
   assign limit_wide     = CMP_W'(limit_ff);
   assign run_len        = CMP_W'(req_data.in_byte[6:0]) + CMP_W'(1);
   assign run_sum        = produced_wide + run_len;
   assign run_next       = LEN_WIDTH'(run_sum);
   assign lit_next       = produced_ff + LEN_WIDTH'(1);
   assign run_over       = run_sum > limit_wide;
   assign at_limit       = produced_wide >= limit_wide;
   assign produced_total = 16'(produced_wide);

   // classify the byte and decide the command
   always_comb begin
      in_literal_in    = in_literal_ff;
      literal_left_in  = literal_left_ff;
      produced_in      = produced_ff;
      failed_in        = failed_ff;
      limit_reached_in = limit_reached_ff;
      fail_code        = rtd_pkg::STATUS_OK;
      clear            = 1'b0;
      cmd_push         = 1'b0;
      cmd.kind         = rtd_pkg::CMD_STATUS;
      cmd.data         = 8'd0;
      cmd.count        = 8'd0;
      cmd.final_flag   = 1'b1;
      cmd.status       = rtd_pkg::STATUS_OK;
      cmd.total        = 16'd0;

      if (accept) begin
         if (failed_ff != rtd_pkg::STATUS_OK || limit_reached_ff) begin
            // stream already settled, wait for its end
            if (req_data.in_last) begin
               cmd_push   = 1'b1;
               cmd.status = failed_ff;
               cmd.total  = (failed_ff == rtd_pkg::STATUS_OK) ? produced_total : 16'd0;
               clear      = 1'b1;
            end
         end else if (in_literal_ff) begin
            if (req_data.in_last && literal_left_ff > 8'd1) begin
               // literal run cut off by the end of the stream
               cmd_push   = 1'b1;
               cmd.status = rtd_pkg::STATUS_CORRUPT;
               clear      = 1'b1;
            end else begin
               produced_in     = lit_next;
               literal_left_in = literal_left_ff - 8'd1;
               in_literal_in   = (literal_left_ff != 8'd1);
               cmd_push        = 1'b1;
               cmd.kind        = rtd_pkg::CMD_LITERAL;
               cmd.data        = req_data.in_byte;
               cmd.count       = 8'd1;
               cmd.final_flag  = req_data.in_last;
               cmd.total       = req_data.in_last ? 16'(CMP_W'(lit_next)) : 16'd0;
               clear           = req_data.in_last;
            end
         end else if (at_limit) begin
            // limit reached or passed: drop the rest of the stream
            limit_reached_in = 1'b1;
            if (req_data.in_last) begin
               cmd_push   = 1'b1;
               cmd.total  = produced_total;
               clear      = 1'b1;
            end
         end else if (req_data.in_byte < rtd_pkg::TAG_SPLIT) begin
            // literal tag
            if (run_over) begin
               fail_code = rtd_pkg::STATUS_LIMIT;
            end else if (req_data.in_last) begin
               fail_code = rtd_pkg::STATUS_CORRUPT;
            end else begin
               in_literal_in   = 1'b1;
               literal_left_in = 8'(run_len);
            end
            failed_in = fail_code;
            if (req_data.in_last) begin
               cmd_push   = 1'b1;
               cmd.status = fail_code;
               clear      = 1'b1;
            end
         end else begin
            // repeat tag
            if (produced_ff == '0) begin
               fail_code = rtd_pkg::STATUS_CORRUPT;
            end else if (run_over) begin
               fail_code = rtd_pkg::STATUS_LIMIT;
            end
            failed_in = fail_code;
            if (fail_code == rtd_pkg::STATUS_OK) begin
               produced_in    = run_next;
               cmd_push       = 1'b1;
               cmd.kind       = rtd_pkg::CMD_REPEAT;
               cmd.count      = 8'(run_len);
               cmd.final_flag = req_data.in_last;
               cmd.total      = req_data.in_last ? 16'(CMP_W'(run_next)) : 16'd0;
               clear          = req_data.in_last;
            end else if (req_data.in_last) begin
               cmd_push   = 1'b1;
               cmd.status = fail_code;
               clear      = 1'b1;
            end
         end

         // end of stream: back to a fresh stream
         if (clear) begin
            in_literal_in    = 1'b0;
            literal_left_in  = 8'd0;
            produced_in      = '0;
            failed_in        = rtd_pkg::STATUS_OK;
            limit_reached_in = 1'b0;
         end
      end
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_literal_ff    <= 1'b0;
         literal_left_ff  <= 8'd0;
         produced_ff      <= '0;
         failed_ff        <= rtd_pkg::STATUS_OK;
         limit_reached_ff <= 1'b0;
      end else begin
         in_literal_ff    <= in_literal_in;
         literal_left_ff  <= literal_left_in;
         produced_ff      <= produced_in;
         failed_ff        <= failed_in;
         limit_reached_ff <= limit_reached_in;
      end
   end

   // output limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

endmodule

FILE: rtl/rtd_queue.sv
// ----------------------------------------------------------------------------
// rtd_queue
// Small command queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module rtd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rtd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output rtd_pkg::cmd_type head_cmd
);

   rtd_pkg::cmd_type                entry_ff [rtd_pkg::QUEUE_DEPTH];
   logic [rtd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rtd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rtd_pkg::QPTR_W:0]        level_ff, level_in;

   assign full       = (level_ff == (rtd_pkg::QPTR_W+1)'(rtd_pkg::QUEUE_DEPTH));
   assign head_valid = (level_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/rtd_back.sv
// ----------------------------------------------------------------------------
// rtd_back
// Carries out commands: tracks the last byte and fills the result register.
// ----------------------------------------------------------------------------
module rtd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  rtd_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rtd_pkg::rsp_data_type rsp_data
);

   logic                  rsp_valid_ff, rsp_valid_in;
   rtd_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic [7:0]            last_output_ff;

   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // build the result from the command
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end
      rsp_data_in.out_count  = cmd.count;
      rsp_data_in.out_final  = cmd.final_flag;
      rsp_data_in.out_status = cmd.status;
      rsp_data_in.out_total  = cmd.total;
      case (cmd.kind)
         rtd_pkg::CMD_LITERAL: rsp_data_in.out_byte = cmd.data;
         rtd_pkg::CMD_REPEAT:  rsp_data_in.out_byte = last_output_ff;
         default:              rsp_data_in.out_byte = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload and last decoded byte
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_data_ff <= rsp_data_in;
         if (cmd.kind == rtd_pkg::CMD_LITERAL) begin
            last_output_ff <= cmd.data;
         end
      end
   end

endmodule

FILE: rtl/rle_tag_stream_decoder.sv
// A req transfer reaches rsp_valid through the queue entry, then the
// result register.
// Throughput: one compressed byte per cycle; the front stalls only while the
// two-entry command queue is full, which needs rsp_ready to have been held low.
// Reset (synchronous, active high) clears the stream state and the queue,
// drops any pending result and sets the output limit to 65535.
// ----------------------------------------------------------------------------
// rle_tag_stream_decoder
// Run-length tag stream decoder: literal runs and repeats of the last byte.
// ----------------------------------------------------------------------------
module rle_tag_stream_decoder #(
   parameter int LEN_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rtd_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rtd_pkg::rsp_data_type rsp_data
);

   logic             queue_full;
   logic             cmd_push;
   rtd_pkg::cmd_type push_cmd;
   logic             cmd_pop;
   logic             head_valid;
   rtd_pkg::cmd_type head_cmd;

   // classify bytes and track the stream
   rtd_front #(
      .LEN_WIDTH(LEN_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .queue_full  (queue_full),
      .req_ready   (req_ready),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   // decoupling queue
   rtd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .pop        (cmd_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // build results
   rtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      !(cmd_push && queue_full))
      else $error("command pushed into a full queue");

   // an error final result carries no byte and no total
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_final &&
       rsp_data.out_status != rtd_pkg::STATUS_OK)
      |-> (rsp_data.out_count == 8'd0 && rsp_data.out_total == 16'd0))
      else $error("error result carries data");

   // a result that is not final carries data and no status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.out_final)
      |-> (rsp_data.out_count != 8'd0 && rsp_data.out_status == rtd_pkg::STATUS_OK &&
           rsp_data.out_total == 16'd0))
      else $error("malformed intermediate result");

   // a popped command always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_valid)
      else $error("popped command lost");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rle_tag_stream_decoder. Compressed streams go in
// over the req channel, and a scoreboard model of the decoder predicts every
// result. Directed cases cover literal runs, repeats, cut-off runs and the
// output limit. Random well-formed streams and noise follow, with random
// gaps and stalls on both channels and limit changes between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TOTAL_ITEMS = 500;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [15:0]           csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   rtd_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rtd_pkg::rsp_data_type rsp_data;

   rle_tag_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // decoder model state
   logic [15:0]         limit_reg = 16'hFFFF;
   logic                lit_active = 1'b0;
   logic [7:0]          lit_left = '0;
   logic [7:0]          prev_out = '0;
   logic [15:0]         out_len = '0;
   rtd_pkg::status_type fail_code = rtd_pkg::STATUS_OK;
   logic                limit_hit = 1'b0;

   rtd_pkg::rsp_data_type pending_rsp[$];
   rtd_pkg::req_data_type stream_q[$];

   bit idle_off = 1'b0;
   int fail_count = 0;
   int cycle_count = 0;
   int live_bytes = 0;
   int req_count = 0;
   int rsp_count = 0;
   int stream_count = 0;
   int limit_writes = 0;

   // ---------------------------------------------------------------------
   // scoreboard model
   // ---------------------------------------------------------------------
   function automatic void push_pending(input logic [7:0] b, input logic [7:0] cnt,
                                        input logic fin, input rtd_pkg::status_type st,
                                        input logic [15:0] tot);
      rtd_pkg::rsp_data_type e;
      e.out_byte   = b;
      e.out_count  = cnt;
      e.out_final  = fin;
      e.out_status = st;
      e.out_total  = tot;
      pending_rsp.push_back(e);
   endfunction

   function automatic void clear_stream();
      lit_active = 1'b0;
      lit_left   = '0;
      out_len    = '0;
      fail_code  = rtd_pkg::STATUS_OK;
      limit_hit  = 1'b0;
   endfunction

   // status-only final, total is 0 on error
   function automatic void finish_status();
      push_pending(8'h00, 8'h00, 1'b1, fail_code,
                   (fail_code != rtd_pkg::STATUS_OK) ? 16'h0000 : out_len);
      clear_stream();
   endfunction

   function automatic void decode_step(input rtd_pkg::req_data_type d);
      logic [8:0]  n;
      logic [16:0] sum;
      if (fail_code != rtd_pkg::STATUS_OK || limit_hit) begin
         if (d.in_last) finish_status();
         return;
      end
      live_bytes++;
      // literal byte of a run
      if (lit_active) begin
         if (d.in_last && lit_left > 8'd1) begin
            fail_code = rtd_pkg::STATUS_CORRUPT;
            finish_status();
            return;
         end
         prev_out = d.in_byte;
         out_len  = out_len + 16'd1;
         lit_left = lit_left - 8'd1;
         if (lit_left == 8'd0) lit_active = 1'b0;
         if (d.in_last) begin
            push_pending(d.in_byte, 8'd1, 1'b1, rtd_pkg::STATUS_OK, out_len);
            clear_stream();
         end else begin
            push_pending(d.in_byte, 8'd1, 1'b0, rtd_pkg::STATUS_OK, 16'h0000);
         end
         return;
      end
      // tag position
      if (out_len >= limit_reg) begin
         limit_hit = 1'b1;
         if (d.in_last) finish_status();
         return;
      end
      if (d.in_byte < rtd_pkg::TAG_SPLIT) begin
         n   = 9'(d.in_byte) + 9'd1;
         sum = 17'(out_len) + 17'(n);
         if (sum > 17'(limit_reg)) begin
            fail_code = rtd_pkg::STATUS_LIMIT;
         end else if (d.in_last) begin
            fail_code = rtd_pkg::STATUS_CORRUPT;
         end else begin
            lit_active = 1'b1;
            lit_left   = n[7:0];
         end
         if (d.in_last) finish_status();
         return;
      end
      // repeat of the last decoded byte
      n   = 9'(d.in_byte - rtd_pkg::TAG_SPLIT) + 9'd1;
      sum = 17'(out_len) + 17'(n);
      if (out_len == 16'd0 || sum > 17'(limit_reg)) begin
         fail_code = (out_len == 16'd0) ? rtd_pkg::STATUS_CORRUPT : rtd_pkg::STATUS_LIMIT;
         if (d.in_last) finish_status();
         return;
      end
      out_len = sum[15:0];
      if (d.in_last) begin
         push_pending(prev_out, n[7:0], 1'b1, rtd_pkg::STATUS_OK, out_len);
         clear_stream();
      end else begin
         push_pending(prev_out, n[7:0], 1'b0, rtd_pkg::STATUS_OK, 16'h0000);
      end
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [7:0] lit_tag(input int run);
      return 8'(run - 1);
   endfunction

   function automatic logic [7:0] rep_tag(input int run);
      return rtd_pkg::TAG_SPLIT + 8'(run - 1);
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic last);
      rtd_pkg::req_data_type d;
      d.in_byte = b;
      d.in_last = last;
      stream_q.push_back(d);
   endfunction

   // one transfer on req; valid stays high across back-to-back items
   task automatic send_byte(input rtd_pkg::req_data_type d, input bit more);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      req_count++;
      decode_step(d);
      if (!more) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++)
         send_byte(stream_q[i], i != stream_q.size() - 1);
      stream_q.delete();
      stream_count++;
   endtask

   // wait for every expected result, then let the pipeline settle
   task automatic wait_drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [15:0] value);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_reg = value;
      limit_writes++;
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------
   task automatic test_repeat_first();
      add_byte(rep_tag(1), 1'b1);
      send_stream();
   endtask

   task automatic test_literal_run();
      // two literals at the byte extremes, then the longest repeat
      add_byte(lit_tag(2), 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(rep_tag(128), 1'b1);
      send_stream();
   endtask

   task automatic test_literal_cutoff();
      // last arrives inside the run
      add_byte(lit_tag(3), 1'b0);
      add_byte(8'h5A, 1'b1);
      send_stream();
      // last arrives on the tag itself, longest literal tag
      add_byte(lit_tag(128), 1'b1);
      send_stream();
   endtask

   task automatic test_limit_overrun();
      set_limit(16'd3);
      // literal run too long, later bytes are ignored
      add_byte(lit_tag(4), 1'b0);
      add_byte(8'h11, 1'b0);
      add_byte(8'h22, 1'b1);
      send_stream();
      // repeat that would pass the limit
      add_byte(lit_tag(1), 1'b0);
      add_byte(8'h33, 1'b0);
      add_byte(rep_tag(3), 1'b1);
      send_stream();
   endtask

   task automatic test_limit_exact();
      // limit met exactly, the rest of the stream is dropped
      add_byte(lit_tag(3), 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h03, 1'b0);
      add_byte(rep_tag(1), 1'b0);
      add_byte(8'h44, 1'b1);
      send_stream();
      // zero limit: the first tag is already at the limit
      set_limit(16'd0);
      add_byte(lit_tag(1), 1'b1);
      send_stream();
   endtask

   task automatic test_limit_midstream();
      set_limit(16'hFFFF);
      add_byte(lit_tag(2), 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h55, 1'b0);
      send_stream();
      // lower the limit while the stream is open
      set_limit(16'd2);
      add_byte(rep_tag(1), 1'b1);
      send_stream();
   endtask

   task automatic test_long_repeat();
      // large total, reaches the top bit of out_total
      set_limit(16'hFFFF);
      idle_off = 1'b1;
      add_byte(lit_tag(1), 1'b0);
      add_byte(8'hC3, 1'b0);
      for (int i = 0; i < 300; i++) add_byte(rep_tag(128), i == 299);
      send_stream();
      idle_off = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // random streams
   // ---------------------------------------------------------------------
   task automatic build_good_stream();
      int nseg;
      int run;
      bit have_out;
      have_out = 1'b0;
      nseg = $urandom_range(1, 6);
      for (int s = 0; s < nseg; s++) begin
         if (have_out && $urandom_range(0, 2) == 0) begin
            add_byte(rep_tag($urandom_range(1, 128)), 1'b0);
         end else begin
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128)
                                               : $urandom_range(1, 8);
            add_byte(lit_tag(run), 1'b0);
            repeat (run) add_byte(8'($urandom_range(0, 255)), 1'b0);
            have_out = 1'b1;
         end
      end
   endtask

   task automatic mark_last();
      rtd_pkg::req_data_type d;
      d = stream_q.pop_back();
      d.in_last = 1'b1;
      stream_q.push_back(d);
   endtask

   task automatic pick_limit();
      case ($urandom_range(0, 4))
         0: set_limit(16'hFFFF);
         1: set_limit(16'd0);
         2: set_limit(16'($urandom_range(1, 40)));
         3: set_limit(16'($urandom_range(41, 2000)));
         default: set_limit(16'($urandom_range(0, 65535)));
      endcase
   endtask

   task automatic test_random_streams();
      int cut;
      set_limit(16'hFFFF);
      while (req_count < TOTAL_ITEMS) begin
         if ($urandom_range(0, 7) == 0) pick_limit();
         idle_off = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            // truncated stream
            0, 1: begin
               build_good_stream();
               cut = $urandom_range(1, stream_q.size());
               while (stream_q.size() > cut) void'(stream_q.pop_back());
               mark_last();
            end
            // raw noise with stray last flags
            2: begin
               repeat ($urandom_range(1, 12))
                  add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
               mark_last();
            end
            default: begin
               build_good_stream();
               mark_last();
            end
         endcase
         send_stream();
         // hold off now and then until everything is out
         if ($urandom_range(0, 15) == 0) wait_drain();
      end
      idle_off = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls per transfer
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = idle_off ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rtd_pkg::rsp_data_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected result byte=%h count=%0d final=%b status=%0d total=%0d",
                        $realtime, rsp_data.out_byte, rsp_data.out_count, rsp_data.out_final,
                        rsp_data.out_status, rsp_data.out_total);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.out_byte !== e.out_byte || rsp_data.out_count !== e.out_count ||
                rsp_data.out_final !== e.out_final || rsp_data.out_status !== e.out_status ||
                rsp_data.out_total !== e.out_total) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: mismatch on result %0d", $realtime, rsp_count);
                  $display("   expected byte=%h count=%0d final=%b status=%0d total=%0d",
                           e.out_byte, e.out_count, e.out_final, e.out_status, e.out_total);
                  $display("   actual   byte=%h count=%0d final=%b status=%0d total=%0d",
                           rsp_data.out_byte, rsp_data.out_count, rsp_data.out_final,
                           rsp_data.out_status, rsp_data.out_total);
               end
            end
         end
      end
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_repeat_first();
      test_literal_run();
      test_literal_cutoff();
      test_limit_overrun();
      test_limit_exact();
      test_limit_midstream();
      test_long_repeat();
      test_random_streams();

      wait_drain();
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         fail_count++;
         $display("%0d expected results never arrived", pending_rsp.size());
      end

      $display("covered %0d streams, %0d input transfers (%0d decoded), %0d results",
               stream_count, req_count, live_bytes, rsp_count);
      $display("limit register written %0d times, %0d failures", limit_writes, fail_count);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
